// ----- rtl/core/pub_pkg.sv -----
// pub_pkg: shared types, constants, helpers and the control store
// of the pcm upsampler with biquad low-pass.
// no dependencies; used by every module of the block.
`default_nettype none

package pub_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int RATIO_W  = 6;
  localparam int LVL_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 3;

  // shared multiplier and accumulator
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 40;

  // interpolation divider: |num| < 2^21, quotient fits 16 bits
  localparam int DIV_N_W   = 21;
  localparam int DIV_Q_W   = 16;
  localparam int DIV_ITERS = DIV_Q_W;
  localparam int LOOP_W    = $clog2(DIV_ITERS);

  // divide by 15 through ceil(2^19 / 15), one correction step
  localparam int RECIP_SH = 19;
  localparam int LQ_W     = 17;
  localparam logic [16:0] RECIP15 = 17'd34953;

  localparam logic [BYTE_W-1:0] SILENCE = 8'h80;
  localparam int PC_W = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_S1_B1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S1_A1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S1_A2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_S2_B1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_S2_A1      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_S2_A2      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 3'd7;

  typedef enum logic [2:0] {
    A_P0, A_P1, A_SUM, A_Y1, A_Y2, A_ABSX, A_PREG
  } a_sel_e;

  typedef enum logic [2:0] {
    B_B1, B_A1, B_A2, B_RMC, B_CNT, B_LVL_L, B_LVL_R, B_RECIP
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB2
  } acc_op_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_TAKE, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_END,
    OP_ROUND, OP_LVL_FIX, OP_OUT_L, OP_OUT_R
  } dp_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_LOOP, SEQ_END
  } seq_op_e;

  typedef enum logic {
    ST_IDLE, ST_RUN
  } state_e;

  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    stage;
    dp_op_e  dp_op;
    seq_op_e seq_op;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   run;
    logic   commit;
  } ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

  function automatic uword_t mk(input a_sel_e a, input b_sel_e b, input acc_op_e ac,
                                input logic st, input dp_op_e op, input seq_op_e sq);
    uword_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = ac;
    w.stage  = st;
    w.dp_op  = op;
    w.seq_op = sq;
    return w;
  endfunction

  // control store: the product register lags the operand selects, so
  // accumulate fields act on the previous step's product
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      // interpolation
      5'd0:  w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_TAKE,     SEQ_NEXT);
      5'd1:  w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd2:  w = mk(A_P1,   B_CNT,   ACC_LOAD, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd3:  w = mk(A_P0,   B_RMC,   ACC_ADD,  1'b0, OP_NONE,     SEQ_NEXT);
      5'd4:  w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_DIV_LOAD, SEQ_NEXT);
      5'd5:  w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_DIV_STEP, SEQ_LOOP);
      5'd6:  w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_DIV_END,  SEQ_NEXT);
      // first biquad
      5'd7:  w = mk(A_SUM,  B_B1,    ACC_HOLD, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd8:  w = mk(A_Y1,   B_A1,    ACC_LOAD, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd9:  w = mk(A_Y2,   B_A2,    ACC_SUB2, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd10: w = mk(A_Y2,   B_A2,    ACC_SUB2, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd11: w = mk(A_Y2,   B_A2,    ACC_HOLD, 1'b0, OP_ROUND,    SEQ_NEXT);
      // second biquad
      5'd12: w = mk(A_SUM,  B_B1,    ACC_HOLD, 1'b1, OP_NONE,     SEQ_NEXT);
      5'd13: w = mk(A_Y1,   B_A1,    ACC_LOAD, 1'b1, OP_NONE,     SEQ_NEXT);
      5'd14: w = mk(A_Y2,   B_A2,    ACC_SUB2, 1'b1, OP_NONE,     SEQ_NEXT);
      5'd15: w = mk(A_Y2,   B_A2,    ACC_SUB2, 1'b1, OP_NONE,     SEQ_NEXT);
      5'd16: w = mk(A_Y2,   B_A2,    ACC_HOLD, 1'b1, OP_ROUND,    SEQ_NEXT);
      // levels, left and right interleaved
      5'd17: w = mk(A_ABSX, B_LVL_L, ACC_HOLD, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd18: w = mk(A_PREG, B_RECIP, ACC_LOAD, 1'b0, OP_NONE,     SEQ_NEXT);
      5'd19: w = mk(A_ABSX, B_LVL_R, ACC_HOLD, 1'b0, OP_LVL_FIX,  SEQ_NEXT);
      5'd20: w = mk(A_PREG, B_RECIP, ACC_LOAD, 1'b0, OP_OUT_L,    SEQ_NEXT);
      5'd21: w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_LVL_FIX,  SEQ_NEXT);
      5'd22: w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_OUT_R,    SEQ_NEXT);
      5'd23: w = mk(A_P0,   B_RMC,   ACC_HOLD, 1'b0, OP_NONE,     SEQ_END);
      default: w = mk(A_P0, B_RMC,   ACC_HOLD, 1'b0, OP_NONE,     SEQ_END);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pub_div.sv -----
// pub_div: restoring divider, one quotient bit per cycle while step is high, for the
// interpolation divide by the ratio. depends on pub_pkg.
`default_nettype none

module pub_div (
  input  logic                              clk_i,
  input  pub_pkg::div_ctl_t                 ctl_i,
  input  logic [pub_pkg::DIV_N_W-1:0]       dividend_i,
  input  logic [pub_pkg::RATIO_W-1:0]       divisor_i,
  output logic [pub_pkg::DIV_Q_W-1:0]       quot_o
);

  logic [pub_pkg::RATIO_W-1:0] rem_q, rem_d;
  logic [pub_pkg::DIV_Q_W-1:0] quo_q, quo_d;
  logic [pub_pkg::RATIO_W:0]   trial;
  logic                        ge;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, quo_q[pub_pkg::DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctl_i.load) begin
      // top bits are always below the divisor, so 16 steps suffice
      rem_d = pub_pkg::RATIO_W'(dividend_i[pub_pkg::DIV_N_W-1:pub_pkg::DIV_Q_W]);
      quo_d = dividend_i[pub_pkg::DIV_Q_W-1:0];
    end else if (ctl_i.step) begin
      rem_d = ge ? pub_pkg::RATIO_W'(trial - {1'b0, divisor_i})
                 : trial[pub_pkg::RATIO_W-1:0];
      quo_d = {quo_q[pub_pkg::DIV_Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/pub_seq.sv -----
// pub_seq: step counter, loop counter and control store readout.
// depends on pub_pkg (state type, control word, ucode table).
`default_nettype none

module pub_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               out_free_i,
  output logic               busy_o,
  output pub_pkg::ctl_t      ctl_o
);

  pub_pkg::state_e              state_q, state_d;
  logic [pub_pkg::PC_W-1:0]     pc_q, pc_d;
  logic [pub_pkg::LOOP_W-1:0]   loop_q, loop_d;
  pub_pkg::uword_t              uw;

  assign uw = pub_pkg::ucode(pc_q);

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    loop_d  = loop_q;
    case (state_q)
      pub_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = pub_pkg::ST_RUN;
          pc_d    = '0;
          loop_d  = '0;
        end
      end
      pub_pkg::ST_RUN: begin
        case (uw.seq_op)
          pub_pkg::SEQ_NEXT: begin
            pc_d = pc_q + pub_pkg::PC_W'(1);
          end
          pub_pkg::SEQ_LOOP: begin
            if (loop_q == pub_pkg::LOOP_W'(pub_pkg::DIV_ITERS - 1)) begin
              pc_d   = pc_q + pub_pkg::PC_W'(1);
              loop_d = '0;
            end else begin
              loop_d = loop_q + pub_pkg::LOOP_W'(1);
            end
          end
          pub_pkg::SEQ_END: begin
            if (out_free_i) begin
              state_d = pub_pkg::ST_IDLE;
              pc_d    = '0;
            end
          end
          default: begin
            state_d = pub_pkg::ST_IDLE;
            pc_d    = '0;
          end
        endcase
      end
      default: begin
        state_d = pub_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl_o.uw     = uw;
    ctl_o.run    = (state_q == pub_pkg::ST_RUN);
    ctl_o.commit = (state_q == pub_pkg::ST_RUN) && (uw.seq_op == pub_pkg::SEQ_END)
                   && out_free_i;
    busy_o       = (state_q != pub_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pub_pkg::ST_IDLE;
      pc_q    <= '0;
      loop_q  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      loop_q  <= loop_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pub_dp.sv -----
// pub_dp: datapath driven by the control word: tick counter, history,
// shared multiplier, accumulator, level scaling. depends on pub_pkg, pub_div.
`default_nettype none

module pub_dp #(
  parameter int COUNT_BITS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pub_pkg::ctl_t                        ctl_i,
  input  logic [pub_pkg::RATIO_W-1:0]          step_ratio_i,
  input  pub_pkg::coef_t                       coef_s0_i,
  input  pub_pkg::coef_t                       coef_s1_i,
  input  logic [pub_pkg::LVL_W-1:0]            levels_i,
  input  logic [pub_pkg::BYTE_W-1:0]           in_byte_i,
  input  logic                                 in_ready_i,
  output logic signed [pub_pkg::SAMPLE_W-1:0]  res_left_o,
  output logic signed [pub_pkg::SAMPLE_W-1:0]  res_right_o,
  output logic                                 res_taken_o
);

  localparam int CW = (COUNT_BITS > pub_pkg::RATIO_W) ? COUNT_BITS : pub_pkg::RATIO_W;

  // state kept from tick to tick
  logic [COUNT_BITS-1:0]               cnt_q;
  logic signed [pub_pkg::SAMPLE_W-1:0] p0_q, p1_q;
  pub_pkg::hist_t                      hist_q [2];

  // working registers
  logic signed [pub_pkg::SAMPLE_W-1:0] x_q;
  logic signed [pub_pkg::PROD_W-1:0]   p_q;
  logic signed [pub_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [pub_pkg::LQ_W-1:0]            q_q;
  logic                                sign_q;
  logic                                taken_q;
  logic signed [pub_pkg::SAMPLE_W-1:0] left_q, right_q;

  logic [pub_pkg::RATIO_W-1:0]         ratio, c6, rmc;
  logic [CW-1:0]                       ratio_ext, cmax_ext;
  logic                                take;
  logic [pub_pkg::BYTE_W-1:0]          byte_eff;

  pub_pkg::hist_t                      cur_h;
  pub_pkg::coef_t                      cur_c;
  logic signed [pub_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [pub_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [pub_pkg::PROD_W-1:0]   prod;
  logic signed [18:0]                  sum19;
  logic signed [16:0]                  xs, abs_x;

  logic signed [pub_pkg::ACC_W-1:0]    acc_abs, rnd, qv, lv;
  logic signed [pub_pkg::SAMPLE_W-1:0] y;
  pub_pkg::div_ctl_t                   div_ctl;
  logic [pub_pkg::DIV_Q_W-1:0]         quot;

  logic [pub_pkg::LQ_W-1:0]            q0, q_fix;
  logic [21:0]                         q15;
  logic [19:0]                         m;

  // effective ratio: zero acts as one, clamp to the counter range
  assign ratio_ext = CW'(step_ratio_i);
  assign cmax_ext  = CW'({COUNT_BITS{1'b1}});

  always_comb begin
    if (step_ratio_i == '0) begin
      ratio = pub_pkg::RATIO_W'(1);
    end else if (ratio_ext > cmax_ext) begin
      ratio = pub_pkg::RATIO_W'(cmax_ext);
    end else begin
      ratio = step_ratio_i;
    end
  end

  assign take     = CW'(cnt_q) >= CW'(ratio);
  assign byte_eff = in_ready_i ? in_byte_i : pub_pkg::SILENCE;
  // after the take step the count is below the ratio
  assign c6       = pub_pkg::RATIO_W'(cnt_q);
  assign rmc      = ratio - c6;

  assign cur_h = hist_q[ctl_i.uw.stage];
  assign cur_c = ctl_i.uw.stage ? coef_s1_i : coef_s0_i;

  // x + 2*x1 + x2
  assign sum19 = 19'(x_q) + (19'($signed(cur_h.x1)) <<< 1) + 19'($signed(cur_h.x2));
  assign xs    = 17'(x_q);
  assign abs_x = xs[16] ? -xs : xs;

  // operand selection for the shared multiplier
  always_comb begin
    case (ctl_i.uw.a_sel)
      pub_pkg::A_P0:   mul_a = pub_pkg::MUL_A_W'(p0_q);
      pub_pkg::A_P1:   mul_a = pub_pkg::MUL_A_W'(p1_q);
      pub_pkg::A_SUM:  mul_a = pub_pkg::MUL_A_W'(sum19);
      pub_pkg::A_Y1:   mul_a = pub_pkg::MUL_A_W'($signed(cur_h.y1));
      pub_pkg::A_Y2:   mul_a = pub_pkg::MUL_A_W'($signed(cur_h.y2));
      pub_pkg::A_ABSX: mul_a = pub_pkg::MUL_A_W'(abs_x);
      pub_pkg::A_PREG: mul_a = $signed(p_q[pub_pkg::MUL_A_W-1:0]);
      default:         mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctl_i.uw.b_sel)
      pub_pkg::B_B1:    mul_b = $signed(cur_c.b1);
      pub_pkg::B_A1:    mul_b = $signed(cur_c.a1);
      pub_pkg::B_A2:    mul_b = $signed(cur_c.a2);
      pub_pkg::B_RMC:   mul_b = $signed(pub_pkg::MUL_B_W'(rmc));
      pub_pkg::B_CNT:   mul_b = $signed(pub_pkg::MUL_B_W'(c6));
      pub_pkg::B_LVL_L: mul_b = $signed(pub_pkg::MUL_B_W'(levels_i[3:0]));
      pub_pkg::B_LVL_R: mul_b = $signed(pub_pkg::MUL_B_W'(levels_i[7:4]));
      pub_pkg::B_RECIP: mul_b = $signed(pub_pkg::MUL_B_W'(pub_pkg::RECIP15));
      default:          mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // accumulator works on last step's product
  always_comb begin
    case (ctl_i.uw.acc_op)
      pub_pkg::ACC_HOLD: acc_d = acc_q;
      pub_pkg::ACC_LOAD: acc_d = pub_pkg::ACC_W'(p_q);
      pub_pkg::ACC_ADD:  acc_d = acc_q + pub_pkg::ACC_W'(p_q);
      pub_pkg::ACC_SUB2: acc_d = acc_q - (pub_pkg::ACC_W'(p_q) <<< 1);
      default:           acc_d = acc_q;
    endcase
  end

  // rounding, ties upward, floor shift by 16
  assign rnd = acc_q + 40'sd32768;
  assign y   = pub_pkg::sat16(rnd >>> 16);

  // divider hookup
  assign acc_abs      = acc_q[pub_pkg::ACC_W-1] ? -acc_q : acc_q;
  assign div_ctl.load = ctl_i.run && (ctl_i.uw.dp_op == pub_pkg::OP_DIV_LOAD);
  assign div_ctl.step = ctl_i.run && (ctl_i.uw.dp_op == pub_pkg::OP_DIV_STEP);

  pub_div u_div (
    .clk_i      (clk_i),
    .ctl_i      (div_ctl),
    .dividend_i (acc_abs[pub_pkg::DIV_N_W-1:0]),
    .divisor_i  (ratio),
    .quot_o     (quot)
  );

  assign qv = $signed(pub_pkg::ACC_W'(quot));

  // level: estimate from the reciprocal, at most one too high
  assign q0    = p_q[pub_pkg::RECIP_SH+pub_pkg::LQ_W-1:pub_pkg::RECIP_SH];
  assign m     = acc_q[19:0];
  assign q15   = (22'(q0) << 4) - 22'(q0);
  assign q_fix = (q15 > 22'(m)) ? q0 - pub_pkg::LQ_W'(1) : q0;
  assign lv    = x_q[pub_pkg::SAMPLE_W-1] ? -$signed(pub_pkg::ACC_W'(q_q))
                                           : $signed(pub_pkg::ACC_W'(q_q));

  // tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      p0_q  <= '0;
      p1_q  <= '0;
      for (int i = 0; i < 2; i++) begin
        hist_q[i] <= '0;
      end
    end else if (ctl_i.run) begin
      if (ctl_i.uw.dp_op == pub_pkg::OP_TAKE && take) begin
        cnt_q <= '0;
        p0_q  <= p1_q;
        p1_q  <= $signed({byte_eff ^ pub_pkg::SILENCE, 8'h00});
      end else if (ctl_i.commit) begin
        cnt_q <= cnt_q + COUNT_BITS'(1);
      end
      if (ctl_i.uw.dp_op == pub_pkg::OP_ROUND) begin
        hist_q[ctl_i.uw.stage].x2 <= cur_h.x1;
        hist_q[ctl_i.uw.stage].x1 <= x_q;
        hist_q[ctl_i.uw.stage].y2 <= cur_h.y1;
        hist_q[ctl_i.uw.stage].y1 <= y;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    p_q   <= prod;
    acc_q <= acc_d;
    if (ctl_i.run) begin
      case (ctl_i.uw.dp_op)
        pub_pkg::OP_TAKE:     taken_q <= take && in_ready_i;
        pub_pkg::OP_DIV_LOAD: sign_q  <= acc_q[pub_pkg::ACC_W-1];
        pub_pkg::OP_DIV_END:  x_q     <= pub_pkg::sat16(sign_q ? -qv : qv);
        pub_pkg::OP_ROUND:    x_q     <= y;
        pub_pkg::OP_LVL_FIX:  q_q     <= q_fix;
        pub_pkg::OP_OUT_L:    left_q  <= pub_pkg::sat16(lv);
        pub_pkg::OP_OUT_R:    right_q <= pub_pkg::sat16(lv);
        default: ;
      endcase
    end
  end

  assign res_left_o  = left_q;
  assign res_right_o = right_q;
  assign res_taken_o = taken_q;

endmodule

`default_nettype wire

// ----- rtl/core/pcm_upsampler_biquad_lowpass.sv -----
// pcm_upsampler_biquad_lowpass: top level, register file, handshakes and
// output register. depends on pub_pkg, pub_seq, pub_dp (and pub_div below it).
//
// usage
// - every beat on the input channel is one output-rate tick. offered_byte_i
//   and byte_ready_i carry the sample the source offers for it; a beat is
//   taken at a rising edge with in_valid_i high and in_stall_o low
// - every input beat gives exactly one output beat: left and right samples
//   plus byte_taken_o, taken at an edge with out_valid_o high and
//   out_stall_i low
// - a microcoded sequencer runs a 24-step program over one shared 21x18
//   multiplier; the interpolation divide loops one quotient bit per cycle
//   and dominates
// - the next beat is taken only once the program for the last one ends
// - configuration writes (index, data) are always ready and land at the
//   accepting edge; write them only between beats
// - reset clears the tick counter, the interpolation points and all filter
//   history, and loads the register reset values (ratio 6, levels full)
// - a stalled receiver holds the result in the output register; the block
//   still takes the next beat and works it up to its last step, then waits
`default_nettype none

module pcm_upsampler_biquad_lowpass #(
  parameter int COUNT_BITS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input beats
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pub_pkg::BYTE_W-1:0]           offered_byte_i,
  input  logic                                 byte_ready_i,
  // output beats
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pub_pkg::SAMPLE_W-1:0]  left_sample_o,
  output logic signed [pub_pkg::SAMPLE_W-1:0]  right_sample_o,
  output logic                                 byte_taken_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pub_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pub_pkg::COEF_W-1:0]           cfg_data_i
);

  // register file
  logic [pub_pkg::RATIO_W-1:0] step_ratio_q;
  pub_pkg::coef_t              coef_s0_q, coef_s1_q;
  logic [pub_pkg::LVL_W-1:0]   levels_q;

  // input capture
  logic [pub_pkg::BYTE_W-1:0]  in_byte_q;
  logic                        in_ready_q;

  // output register
  logic                                out_valid_q;
  logic signed [pub_pkg::SAMPLE_W-1:0] out_left_q, out_right_q;
  logic                                out_taken_q;

  logic                                in_fire, out_free, busy;
  pub_pkg::ctl_t                       ctl;
  logic signed [pub_pkg::SAMPLE_W-1:0] res_left, res_right;
  logic                                res_taken;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_fire     = in_valid_i && !busy;
  // output register is free when empty or being drained this edge
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q <= pub_pkg::RATIO_W'(6);
      coef_s0_q    <= '0;
      coef_s1_q    <= '0;
      levels_q     <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pub_pkg::REG_STEP_RATIO: step_ratio_q <= cfg_data_i[pub_pkg::RATIO_W-1:0];
        pub_pkg::REG_S1_B1:      coef_s0_q.b1 <= $signed(cfg_data_i);
        pub_pkg::REG_S1_A1:      coef_s0_q.a1 <= $signed(cfg_data_i);
        pub_pkg::REG_S1_A2:      coef_s0_q.a2 <= $signed(cfg_data_i);
        pub_pkg::REG_S2_B1:      coef_s1_q.b1 <= $signed(cfg_data_i);
        pub_pkg::REG_S2_A1:      coef_s1_q.a1 <= $signed(cfg_data_i);
        pub_pkg::REG_S2_A2:      coef_s1_q.a2 <= $signed(cfg_data_i);
        pub_pkg::REG_LEVELS:     levels_q     <= cfg_data_i[pub_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the beat's payload for the whole program
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q  <= offered_byte_i;
      in_ready_q <= byte_ready_i;
    end
  end

  pub_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctl_o      (ctl)
  );

  pub_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .step_ratio_i (step_ratio_q),
    .coef_s0_i    (coef_s0_q),
    .coef_s1_i    (coef_s1_q),
    .levels_i     (levels_q),
    .in_byte_i    (in_byte_q),
    .in_ready_i   (in_ready_q),
    .res_left_o   (res_left),
    .res_right_o  (res_right),
    .res_taken_o  (res_taken)
  );

  // output valid: set on commit, cleared once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      out_left_q  <= res_left;
      out_right_q <= res_right;
      out_taken_q <= res_taken;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_left_q;
  assign right_sample_o = out_right_q;
  assign byte_taken_o   = out_taken_q;

  // a result never overwrites one the receiver is still holding off
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !ctl.commit)
    else $error("result committed over a stalled output beat");

  // an accepted beat starts the program at once
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy && ctl.run))
    else $error("sequencer did not start on an accepted beat");

  // after commit the block is ready for the next beat and shows a result
  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> (!in_stall_o && out_valid_o))
    else $error("sequencer not idle or output empty after commit");

endmodule

`default_nettype wire

// ----- dv/tb_pcm_upsampler_biquad_lowpass.sv -----
// tb_pcm_upsampler_biquad_lowpass: self-checking bench for the pcm upsampler
// with two biquad low-pass stages, stereo levels and a tick-level predictor.
// depends on pub_pkg and the rtl of pcm_upsampler_biquad_lowpass only.
`default_nettype none

module tb_pcm_upsampler_biquad_lowpass;

  localparam int CNT_BITS    = 6;
  localparam int CNT_MAX     = (1 << CNT_BITS) - 1;
  // ~1525 beats, with random gaps and stalls between them, stay far below this
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_BEATS = 125;

  // one input beat: the byte the source offers for this tick
  typedef struct packed {
    logic [pub_pkg::BYTE_W-1:0] pcm;
    logic                       rdy;
  } tick_in_t;

  // one output beat: both channels and the byte-taken flag
  typedef struct packed {
    logic signed [pub_pkg::SAMPLE_W-1:0] left;
    logic signed [pub_pkg::SAMPLE_W-1:0] right;
    logic                                taken;
  } tick_out_t;

  // every block input has a known value from time zero
  logic                                 clk_i          = 1'b0;
  logic                                 rst_ni         = 1'b0;
  logic                                 in_valid_i     = 1'b0;
  logic [pub_pkg::BYTE_W-1:0]           offered_byte_i = '0;
  logic                                 byte_ready_i   = 1'b0;
  logic                                 out_stall_i    = 1'b0;
  logic                                 cfg_valid_i    = 1'b0;
  logic [pub_pkg::CFG_IDX_W-1:0]        cfg_index_i    = '0;
  logic [pub_pkg::COEF_W-1:0]           cfg_data_i     = '0;
  logic                                 in_stall_o;
  logic                                 out_valid_o;
  logic signed [pub_pkg::SAMPLE_W-1:0]  left_sample_o;
  logic signed [pub_pkg::SAMPLE_W-1:0]  right_sample_o;
  logic                                 byte_taken_o;
  logic                                 cfg_ready_o;

  pcm_upsampler_biquad_lowpass #(
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .offered_byte_i (offered_byte_i),
    .byte_ready_i   (byte_ready_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .byte_taken_o   (byte_taken_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers and of the block state
  // ---------------------------------------------------------------------------
  logic [pub_pkg::RATIO_W-1:0]         ratio_cfg;
  logic signed [pub_pkg::COEF_W-1:0]   coef_cfg [6];   // b1, a1, a2 of stage 1 then stage 2
  logic [pub_pkg::LVL_W-1:0]           levels_cfg;
  logic [CNT_BITS-1:0]                 tick_cnt;
  logic signed [pub_pkg::SAMPLE_W-1:0] interp_pt [2];  // [0] older, [1] newer
  logic signed [pub_pkg::SAMPLE_W-1:0] filt_hist [8];  // per stage: x1, x2, y1, y2

  // bookkeeping shared by the driver, the monitor and the sequence
  tick_in_t  offered_ticks [$];
  tick_out_t due_samples [$];
  int        beats_planned = 0;
  int        beats_checked = 0;
  int        regs_written  = 0;
  int        mismatches    = 0;
  int        cycle_cnt     = 0;
  bit        calm          = 1'b0;   // no idling on either side when set

  function automatic logic signed [pub_pkg::SAMPLE_W-1:0] clamp16(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return pub_pkg::SAMPLE_W'(v);
  endfunction

  task automatic clear_model();
    ratio_cfg  = pub_pkg::RATIO_W'(6);
    levels_cfg = 8'hff;
    tick_cnt   = '0;
    for (int i = 0; i < 6; i++) coef_cfg[i] = '0;
    for (int i = 0; i < 2; i++) interp_pt[i] = '0;
    for (int i = 0; i < 8; i++) filt_hist[i] = '0;
  endtask

  task automatic apply_reg(input logic [pub_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pub_pkg::COEF_W-1:0] val);
    case (idx)
      pub_pkg::REG_STEP_RATIO: ratio_cfg  = val[pub_pkg::RATIO_W-1:0];
      pub_pkg::REG_LEVELS:     levels_cfg = val[pub_pkg::LVL_W-1:0];
      default:                 coef_cfg[idx - pub_pkg::REG_S1_B1] = val;
    endcase
  endtask

  // direct form I with b0 = b2 = b1/2; history shifts once per tick
  function automatic logic signed [pub_pkg::SAMPLE_W-1:0] biquad_stage(
      input int s, input logic signed [pub_pkg::SAMPLE_W-1:0] x);
    longint acc;
    logic signed [pub_pkg::SAMPLE_W-1:0] y;
    acc = longint'(coef_cfg[3*s]) * (longint'(x) + 2 * longint'(filt_hist[4*s])
                                     + longint'(filt_hist[4*s+1]))
        - 2 * longint'(coef_cfg[3*s+1]) * longint'(filt_hist[4*s+2])
        - 2 * longint'(coef_cfg[3*s+2]) * longint'(filt_hist[4*s+3]);
    // round half up: arithmetic shift is a floor
    y = clamp16((acc + 32768) >>> 16);
    filt_hist[4*s+1] = filt_hist[4*s];
    filt_hist[4*s]   = x;
    filt_hist[4*s+3] = filt_hist[4*s+2];
    filt_hist[4*s+2] = y;
    return y;
  endfunction

  task automatic predict_tick(input tick_in_t t, output tick_out_t r);
    longint ratio;
    longint c;
    longint num;
    logic [pub_pkg::BYTE_W-1:0] b;
    logic signed [pub_pkg::SAMPLE_W-1:0] x;
    // zero ratio acts as one, and the counter range caps it
    ratio = (ratio_cfg == 0) ? 1 : longint'(ratio_cfg);
    if (ratio > CNT_MAX) ratio = CNT_MAX;
    r.taken = 1'b0;
    // also covers a ratio lowered below the running count
    if (tick_cnt >= ratio) begin
      b            = t.rdy ? t.pcm : pub_pkg::SILENCE;
      tick_cnt     = '0;
      r.taken      = t.rdy;
      interp_pt[0] = interp_pt[1];
      interp_pt[1] = pub_pkg::SAMPLE_W'((longint'(b) - 128) * 256);
    end
    c   = longint'(tick_cnt);
    num = longint'(interp_pt[0]) * (ratio - c) + longint'(interp_pt[1]) * c;
    x   = clamp16(num / ratio);
    x   = biquad_stage(0, x);
    x   = biquad_stage(1, x);
    r.left   = clamp16(longint'(x) * longint'(levels_cfg[3:0]) / 15);
    r.right  = clamp16(longint'(x) * longint'(levels_cfg[7:4]) / 15);
    tick_cnt = tick_cnt + 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // driver: predicts on every accepted beat, then offers the next one
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk_i) begin : driver
    tick_out_t res;
    tick_in_t  nxt;
    if (!rst_ni) begin
      clear_model();
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_data_i);
        regs_written++;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_tick('{pcm: offered_byte_i, rdy: byte_ready_i}, res);
        due_samples.push_back(res);
      end
      // a stalled beat stays put; otherwise idle or present the next one
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (offered_ticks.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (offered_ticks.size() != 0) begin
          nxt = offered_ticks.pop_front();
          in_valid_i     <= 1'b1;
          offered_byte_i <= nxt.pcm;
          byte_ready_i   <= nxt.rdy;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted output beat, stalls in random bursts
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin : monitor
    tick_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_checked++;
        if (due_samples.size() == 0) begin
          $display("%0t: expected no beat, got left %0d right %0d taken %0b",
                   $time, left_sample_o, right_sample_o, byte_taken_o);
          mismatches++;
        end else begin
          want = due_samples.pop_front();
          if (want.left !== left_sample_o || want.right !== right_sample_o ||
              want.taken !== byte_taken_o) begin
            $display({"%0t: expected left %0d right %0d taken %0b, ",
                      "got left %0d right %0d taken %0b"},
                     $time, want.left, want.right, want.taken,
                     left_sample_o, right_sample_o, byte_taken_o);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_pcm_upsampler_biquad_lowpass NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------------
  task automatic offer(input logic [pub_pkg::BYTE_W-1:0] pcm, input logic rdy);
    offered_ticks.push_back('{pcm: pcm, rdy: rdy});
    beats_planned++;
  endtask

  // every planned beat has come back; the block has no silent beats, so a
  // few spare cycles are enough before touching the registers
  task automatic settle();
    wait (beats_checked == beats_planned);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pub_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pub_pkg::COEF_W-1:0] val);
    int target;
    target = regs_written + 1;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    wait (regs_written == target);
    cfg_valid_i <= 1'b0;
  endtask

  // butterworth-ish low-pass pair near fs/10, jittered; wild picks any 18-bit words
  task automatic tune_filter(input bit wild);
    int nominal;
    logic [pub_pkg::COEF_W-1:0] word;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0:       nominal = 4056;
        1:       nominal = -34361;
        2:       nominal = 9700;
        3:       nominal = 5106;
        4:       nominal = -43280;
        default: nominal = 20732;
      endcase
      word = wild ? pub_pkg::COEF_W'($urandom)
                  : pub_pkg::COEF_W'(nominal + int'($urandom_range(0, 3000)) - 1500);
      write_reg(pub_pkg::CFG_IDX_W'(int'(pub_pkg::REG_S1_B1) + i), word);
    end
  endtask

  // mostly well-formed audio shapes, with the source running dry now and then
  task automatic queue_random_ticks(input int n);
    int shape;
    int base;
    int dry;
    logic [pub_pkg::BYTE_W-1:0] pcm;
    shape = $urandom_range(0, 3);
    base  = $urandom_range(0, 255);
    dry   = (shape == 3) ? 1 : 6;
    for (int i = 0; i < n; i++) begin
      case (shape)
        0:       pcm = pub_pkg::BYTE_W'($urandom);
        1:       pcm = ((i / 8) % 2 != 0) ? 8'hff : 8'h00;   // full-scale square
        2:       pcm = pub_pkg::BYTE_W'(base + 3 * i);       // sawtooth ramp
        default: pcm = $urandom_range(0, 1) ? pub_pkg::BYTE_W'($urandom)
                                            : ($urandom_range(0, 1) ? 8'hff : 8'h00);
      endcase
      offer(pcm, $urandom_range(0, dry) != 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [pub_pkg::RATIO_W-1:0] ratio;
    logic [pub_pkg::LVL_W-1:0]   lvl;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: ratio 6, zero coefficients, full levels
    offer(8'hff, 1'b1);
    offer(8'h00, 1'b1);
    offer(8'h37, 1'b0);
    settle();

    // every register, ratio one so every tick takes a byte
    write_reg(pub_pkg::REG_STEP_RATIO, 18'd1);
    tune_filter(1'b0);
    write_reg(pub_pkg::REG_LEVELS, 18'h000f0);
    offer(8'hff, 1'b1);
    offer(8'h00, 1'b1);
    offer(8'h80, 1'b1);
    offer(8'hff, 1'b0);   // empty source, silence used
    offer(8'h7f, 1'b1);
    offer(8'h81, 1'b1);
    settle();

    // zero ratio behaves as one
    write_reg(pub_pkg::REG_STEP_RATIO, 18'h3ffc0);
    write_reg(pub_pkg::REG_LEVELS, 18'h0000f);
    offer(8'h00, 1'b1);
    offer(8'hff, 1'b1);
    offer(8'h5a, 1'b0);
    settle();

    // widest ratio, then lowered below the running count
    write_reg(pub_pkg::REG_STEP_RATIO, 18'd63);
    write_reg(pub_pkg::REG_LEVELS, 18'h000ff);
    offer(8'hff, 1'b1);
    offer(8'h00, 1'b1);
    offer(8'hff, 1'b1);
    offer(8'h00, 1'b0);
    offer(8'h12, 1'b1);
    offer(8'hee, 1'b1);
    settle();
    write_reg(pub_pkg::REG_STEP_RATIO, 18'd2);
    offer(8'h00, 1'b1);
    offer(8'hff, 1'b1);
    offer(8'h40, 1'b1);
    settle();

    // coefficient extremes drive the stages into saturation
    write_reg(pub_pkg::REG_S1_B1, 18'h1ffff);
    write_reg(pub_pkg::REG_S1_A1, 18'h20000);
    write_reg(pub_pkg::REG_S1_A2, 18'h1ffff);
    write_reg(pub_pkg::REG_S2_B1, 18'h20000);
    write_reg(pub_pkg::REG_S2_A1, 18'h1ffff);
    write_reg(pub_pkg::REG_S2_A2, 18'h20000);
    offer(8'h00, 1'b1);
    offer(8'hff, 1'b1);
    offer(8'h00, 1'b1);
    offer(8'hff, 1'b0);

    // random phases; each waits for the block to drain before reconfiguring
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      calm = (p == RAND_PHASES - 1);
      case (p)
        0:       ratio = pub_pkg::RATIO_W'(63);
        1:       ratio = '0;
        2:       ratio = pub_pkg::RATIO_W'(1);
        default: ratio = ($urandom_range(0, 4) == 0)
                         ? pub_pkg::RATIO_W'($urandom_range(13, 63))
                         : pub_pkg::RATIO_W'($urandom_range(1, 12));
      endcase
      // junk above the register width must be dropped
      write_reg(pub_pkg::REG_STEP_RATIO, {12'($urandom), ratio});
      if (p % 3 == 0 || p == 4 || p == 5) begin
        tune_filter(p == 4);
      end
      case (p)
        0:       lvl = 8'hff;
        1:       lvl = 8'h00;
        default: lvl = pub_pkg::LVL_W'($urandom);
      endcase
      write_reg(pub_pkg::REG_LEVELS, {10'($urandom), lvl});
      queue_random_ticks(PHASE_BEATS);
    end

    settle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("tb_pcm_upsampler_biquad_lowpass OK");
    end else begin
      $display("tb_pcm_upsampler_biquad_lowpass NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
